/* rtl/utf8_case_accent_folder_core_defines.svh */
// ----------------------------------------------------------------------------
// utf8 case and accent folder: assertion macros
// shared concurrent assertion forms used by the folder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_CASE_ACCENT_FOLDER_CORE_DEFINES_SVH
`define UTF8_CASE_ACCENT_FOLDER_CORE_DEFINES_SVH

// same-cycle implication
`define UCAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ucaf: same-cycle check failed");

// next-cycle implication
`define UCAF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ucaf: next-cycle check failed");

`endif

/* rtl/ucaf_pkg.sv */
// ----------------------------------------------------------------------------
// utf8 case and accent folder package
// types, constants and the latin-1 fold table shared by the folder rtl
// ----------------------------------------------------------------------------
package ucaf_pkg;

   localparam int unsigned MAX_RUN = 4;

   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_Z = 8'h5A;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] N_TILDE = 8'hF1;
   localparam logic [7:0] FOLD_A  = 8'h61;
   localparam logic [7:0] FOLD_E  = 8'h65;
   localparam logic [7:0] FOLD_I  = 8'h69;
   localparam logic [7:0] FOLD_O  = 8'h6F;
   localparam logic [7:0] FOLD_U  = 8'h75;
   localparam logic [7:0] FOLD_C  = 8'h63;

   localparam logic [20:0] CP_MAX = 21'h10FFFF;

   typedef struct packed {
      logic [20:0] acc;
      logic [1:0]  pend;
      logic [1:0]  seq;
   } state_type;

   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;
      logic [MAX_RUN-1:0]      bad;
      logic [2:0]              count;
   } run_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c - UPPER_A + LOWER_A;
      end else begin
         case (c)
            8'hD1, 8'hF1: r = N_TILDE;
            8'hC1, 8'hC4, 8'hC5, 8'hE1, 8'hE4, 8'hE5: r = FOLD_A;
            8'hC9, 8'hCB, 8'hE9, 8'hEB: r = FOLD_E;
            8'hCD, 8'hCF, 8'hED, 8'hEF: r = FOLD_I;
            8'hD3, 8'hD6, 8'hD8, 8'hF3, 8'hF6, 8'hF8: r = FOLD_O;
            8'hDA, 8'hDC, 8'hFA, 8'hFC: r = FOLD_U;
            8'hC7, 8'hE7: r = FOLD_C;
            default: r = c;
         endcase
      end
      return r;
   endfunction

endpackage

/* rtl/ucaf_decode.sv */
// ----------------------------------------------------------------------------
// utf8 decode, fold and re-encode
// one input byte against the open sequence state gives the next state
// and the run of up to four result bytes
// ----------------------------------------------------------------------------
module ucaf_decode import ucaf_pkg::*; (
   input  logic [7:0] in_byte,
   input  logic       end_of_string,
   input  state_type  state_ff,
   output state_type  state_in,
   output run_type    run
);

   logic                    cont;
   logic [20:0]             acc_cat;
   logic                    start;
   logic                    bad;
   logic                    pre_bad;
   logic                    emit;
   logic                    invalid;
   logic [20:0]             cp;
   logic [20:0]             fc;
   logic [MAX_RUN-1:0][7:0] enc;
   logic [2:0]              enc_len;

   assign cont    = (in_byte[7:6] == 2'b10);
   assign acc_cat = {state_ff.acc[14:0], in_byte[5:0]};

   always_comb begin
      invalid = ((state_ff.seq == 2'd1) && (acc_cat < 21'h80))    ||
                ((state_ff.seq == 2'd2) && (acc_cat < 21'h800))   ||
                ((state_ff.seq == 2'd3) && (acc_cat < 21'h10000)) ||
                (acc_cat > CP_MAX) ||
                (acc_cat >= 21'hD800 && acc_cat <= 21'hDFFF);
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b1;
      bad      = 1'b0;
      pre_bad  = 1'b0;
      emit     = 1'b0;
      cp       = {13'd0, in_byte};
      if (state_ff.pend != 2'd0) begin
         if (cont) begin
            start         = 1'b0;
            state_in.acc  = acc_cat;
            state_in.pend = state_ff.pend - 2'd1;
            if (state_ff.pend == 2'd1) begin
               if (invalid) begin
                  bad = 1'b1;
               end else begin
                  emit = 1'b1;
                  cp   = acc_cat;
               end
               state_in.acc = '0;
               state_in.seq = 2'd0;
            end
         end else begin
            bad      = 1'b1;
            state_in = '0;
         end
      end
      if (start) begin
         if (!in_byte[7]) begin
            pre_bad = bad;
            bad     = 1'b0;
            emit    = 1'b1;
            cp      = {13'd0, in_byte};
         end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
            state_in.acc  = {16'd0, in_byte[4:0]};
            state_in.pend = 2'd1;
            state_in.seq  = 2'd1;
         end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
            state_in.acc  = {17'd0, in_byte[3:0]};
            state_in.pend = 2'd2;
            state_in.seq  = 2'd2;
         end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
            state_in.acc  = {18'd0, in_byte[2:0]};
            state_in.pend = 2'd3;
            state_in.seq  = 2'd3;
         end else begin
            bad = 1'b1;
         end
      end
      if (end_of_string && state_in.pend != 2'd0) begin
         bad      = 1'b1;
         state_in = '0;
      end
   end

   // only latin-1 code points are folded
   assign fc = (cp[20:8] == 13'd0) ? {13'd0, fold_byte(cp[7:0])} : cp;

   always_comb begin
      enc = '0;
      if (fc < 21'h80) begin
         enc[0]  = fc[7:0];
         enc_len = 3'd1;
      end else if (fc < 21'h800) begin
         enc[0]  = {3'b110, fc[10:6]};
         enc[1]  = {2'b10, fc[5:0]};
         enc_len = 3'd2;
      end else if (fc < 21'h10000) begin
         enc[0]  = {4'b1110, fc[15:12]};
         enc[1]  = {2'b10, fc[11:6]};
         enc[2]  = {2'b10, fc[5:0]};
         enc_len = 3'd3;
      end else begin
         enc[0]  = {5'b11110, fc[20:18]};
         enc[1]  = {2'b10, fc[17:12]};
         enc[2]  = {2'b10, fc[11:6]};
         enc[3]  = {2'b10, fc[5:0]};
         enc_len = 3'd4;
      end
   end

   always_comb begin
      run = '0;
      if (emit && pre_bad) begin
         run.bad[0]   = 1'b1;
         run.bytes[1] = enc[0];
         run.count    = 3'd2;
      end else if (emit) begin
         run.bytes = enc;
         run.count = enc_len;
      end else if (bad) begin
         run.bad[0] = 1'b1;
         run.count  = 3'd1;
      end
   end

endmodule

/* rtl/utf8_case_accent_folder_core.sv */
// ----------------------------------------------------------------------------
// utf8 case and accent folder core
// Takes one UTF-8 byte per transfer and returns the folded re-encoding one
// byte per transfer. A byte that completes a code point gives one to four
// result bytes, a malformed sequence gives one result with the malformed
// flag and a zero byte, and an opening or continuation byte may give none.
// An input transfer is taken every cycle as long as the result bytes of the
// previous byte drain in time: the input is held until the last result of the
// run is taken, set by the single run buffer that feeds the result port one
// byte per cycle while rsp_ready holds. No pass after reset is needed.
// ----------------------------------------------------------------------------
`include "utf8_case_accent_folder_core_defines.svh"

module utf8_case_accent_folder_core import ucaf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_malformed,
   output logic       rsp_string_done
);

   state_type  state_ff;
   state_type  state_in;
   run_type    run_in;
   run_type    run_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic [1:0] last_ff;
   logic       eos_ff;
   logic       take;
   logic       rsp_last;

   ucaf_decode u_decode (
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .state_ff      (state_ff),
      .state_in      (state_in),
      .run           (run_in)
   );

   assign rsp_last  = (idx_ff == last_ff);
   assign req_ready = !valid_ff || (rsp_ready && rsp_last);
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
         last_ff  <= 2'd0;
         eos_ff   <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         if (take && run_in.count != 3'd0) begin
            run_ff   <= run_in;
            valid_ff <= 1'b1;
            idx_ff   <= 2'd0;
            last_ff  <= run_in.count[1:0] - 2'd1;
            eos_ff   <= req_end_of_string;
         end else if (valid_ff && rsp_ready) begin
            if (rsp_last) begin
               valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = run_ff.bytes[idx_ff];
   assign rsp_malformed   = run_ff.bad[idx_ff];
   assign rsp_run_last    = rsp_last;
   assign rsp_string_done = rsp_last && eos_ff;

   `UCAF_ASSERT_IMP(a_bad_zero, clock, reset, rsp_valid && rsp_malformed, rsp_out_byte == 8'd0)
   `UCAF_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_string_done, rsp_run_last)
   `UCAF_ASSERT_IMP(a_no_overrun, clock, reset, rsp_valid && req_ready,
                    rsp_ready && rsp_run_last)
   `UCAF_ASSERT_NXT(a_eos_closes, clock, reset, take && req_end_of_string,
                    state_ff.pend == 2'd0)

endmodule
